/* hdl/lbct_pkg.sv */
// shared constants, codes and types for the lru block cache tag controller
package lbct_pkg;

    localparam int WAYS    = 5;
    localparam int CACHES  = 2;
    localparam int ENTRIES = CACHES * WAYS;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WAY_W   = $clog2(WAYS + 1);

    localparam int SEL_W    = 2;
    localparam int BLK_W    = 32;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 3;
    localparam int WAYIDX_W = 3;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 3;

    localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FILLED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BYPASS = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOZONE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FAILED = 3'd4;

    // result of comparing one way against the request and the oldest so far
    typedef struct packed {
        logic match;
        logic older;
    } cmp_res_t;

endpackage

/* hdl/lbct_way_cmp.sv */
// shared compare unit: tag match and oldest-stamp test for one way
module lbct_way_cmp (
    input  logic [lbct_pkg::BLK_W-1:0]   tag,
    input  logic [lbct_pkg::STAMP_W-1:0] stamp,
    input  logic [lbct_pkg::BLK_W-1:0]   blk,
    input  logic [lbct_pkg::STAMP_W-1:0] best_stamp,
    input  logic                         first,
    output lbct_pkg::cmp_res_t           res
);

    always_comb begin
        res.match = (tag == blk);
        // first way seeds the victim search, later ways must be strictly older
        res.older = first || (stamp < best_stamp);
    end

endmodule

/* hdl/lru_block_cache_tags.sv */
// top level: request sequencer, tag and stamp stores, result register
//
//  channel | ports         | fields, lowest bit first
//  --------+---------------+-------------------------------------------------
//  request | s_t*          | tuser: cache_select[1:0]
//          |               | tdata: block_number[31:0], fill_ok[32], zero pad
//  result  | m_t*          | tuser: status[2:0]
//          |               | tdata: way_index[2:0], zero pad
//
// a cached request is accepted, then walks each way in turn through the shared
// compare unit, then updates the stores and presents the result; no-zone and
// bypass requests finish in the accept cycle.
// aresetn clears tags, stamps and the access counter at once.
// s_tready is low while a request is in flight or the result word is stalled.
module lru_block_cache_tags (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lbct_pkg::S_TDATA_W-1:0]   s_tdata,  // block_number, fill_ok
    input  logic [lbct_pkg::S_TUSER_W-1:0]   s_tuser,  // cache_select
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lbct_pkg::M_TDATA_W-1:0]   m_tdata,  // way_index
    output logic [lbct_pkg::M_TUSER_W-1:0]   m_tuser   // status
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [lbct_pkg::BLK_W-1:0]   tag_store_reg   [lbct_pkg::ENTRIES];
    logic [lbct_pkg::STAMP_W-1:0] stamp_store_reg [lbct_pkg::ENTRIES];
    logic [lbct_pkg::STAMP_W-1:0] counter_reg;

    logic [lbct_pkg::BLK_W-1:0]   blk_reg;
    logic                         fill_reg;
    logic [lbct_pkg::IDX_W-1:0]   base_reg;
    logic [lbct_pkg::WAY_W-1:0]   way_reg;
    logic                         hit_reg;
    logic [lbct_pkg::WAY_W-1:0]   hit_way_reg;
    logic [lbct_pkg::WAY_W-1:0]   vict_way_reg;
    logic [lbct_pkg::STAMP_W-1:0] best_stamp_reg;
    logic [lbct_pkg::WAY_W-1:0]   res_way_reg;
    logic [lbct_pkg::STATUS_W-1:0] res_status_reg;

    logic                          m_valid_reg;
    logic [lbct_pkg::STATUS_W-1:0] m_status_reg;
    logic [lbct_pkg::WAYIDX_W-1:0] m_way_reg;

    logic                         out_free;
    logic                         s_accept;
    logic [lbct_pkg::SEL_W-1:0]   in_sel;
    logic [lbct_pkg::BLK_W-1:0]   in_blk;
    logic                         in_fill;
    logic                         in_nozone;
    logic                         in_bypass;
    logic [lbct_pkg::IDX_W-1:0]   rd_idx;
    logic                         last_way;
    logic [lbct_pkg::WAY_W-1:0]   sel_way;
    logic [lbct_pkg::IDX_W-1:0]   upd_idx;
    logic                         do_write;
    lbct_pkg::cmp_res_t           cmp;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign in_sel    = s_tuser[lbct_pkg::SEL_W-1:0];
    assign in_blk    = s_tdata[lbct_pkg::BLK_W-1:0];
    assign in_fill   = s_tdata[lbct_pkg::BLK_W];
    assign in_nozone = (in_blk == '0);
    assign in_bypass = (32'(in_sel) >= 32'(lbct_pkg::CACHES));

    assign rd_idx   = base_reg + lbct_pkg::IDX_W'(way_reg);
    assign last_way = (way_reg == lbct_pkg::WAY_W'(lbct_pkg::WAYS - 1));
    assign sel_way  = hit_reg ? hit_way_reg : vict_way_reg;
    assign upd_idx  = base_reg + lbct_pkg::IDX_W'(sel_way);
    assign do_write = (state_reg == S_UPDATE) && (hit_reg || fill_reg);

    lbct_way_cmp u_cmp (
        .tag        (tag_store_reg[rd_idx]),
        .stamp      (stamp_store_reg[rd_idx]),
        .blk        (blk_reg),
        .best_stamp (best_stamp_reg),
        .first      (way_reg == '0),
        .res        (cmp)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept && !in_nozone && !in_bypass) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_way) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            blk_reg  <= in_blk;
            fill_reg <= in_fill;
            base_reg <= lbct_pkg::IDX_W'(32'(in_sel) * lbct_pkg::WAYS);
            way_reg  <= '0;
            hit_reg  <= 1'b0;
        end else if (state_reg == S_SCAN) begin
            way_reg <= way_reg + 1'b1;
            if (cmp.match && !hit_reg) begin
                hit_reg     <= 1'b1;
                hit_way_reg <= way_reg;
            end
            if (cmp.older) begin
                vict_way_reg   <= way_reg;
                best_stamp_reg <= stamp_store_reg[rd_idx];
            end
        end
        if (state_reg == S_UPDATE) begin
            res_way_reg <= sel_way;
            if (hit_reg) begin
                res_status_reg <= lbct_pkg::ST_HIT;
            end else if (fill_reg) begin
                res_status_reg <= lbct_pkg::ST_FILLED;
            end else begin
                res_status_reg <= lbct_pkg::ST_FAILED;
            end
        end
    end

    // tag and stamp stores with the shared access counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            for (int i = 0; i < lbct_pkg::ENTRIES; i++) begin
                tag_store_reg[i]   <= '0;
                stamp_store_reg[i] <= '0;
            end
        end else if (do_write) begin
            counter_reg              <= counter_reg + 1'b1;
            stamp_store_reg[upd_idx] <= counter_reg + 1'b1;
            tag_store_reg[upd_idx]   <= blk_reg;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && (in_nozone || in_bypass)) begin
            m_valid_reg <= 1'b1;
        end else if ((state_reg == S_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && in_nozone) begin
            m_status_reg <= lbct_pkg::ST_NOZONE;
            m_way_reg    <= '0;
        end else if (s_accept && in_bypass) begin
            m_status_reg <= lbct_pkg::ST_BYPASS;
            m_way_reg    <= '0;
        end else if ((state_reg == S_DONE) && out_free) begin
            m_status_reg <= res_status_reg;
            m_way_reg    <= lbct_pkg::WAYIDX_W'(res_way_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(lbct_pkg::M_TDATA_W - lbct_pkg::WAYIDX_W){1'b0}}, m_way_reg};

endmodule

/* verif/lbct_checker.sv */
// checker for the lru block cache tag controller: predicts each reply and compares it
module lbct_checker
    import lbct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // block_number[31:0], fill_ok[32], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,  // cache_select[1:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // way_index[2:0], zero pad
    input  logic [M_TUSER_W-1:0] m_tuser,  // status[2:0]
    output int unsigned          mismatches,
    output int unsigned          awaiting
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WAYIDX_W-1:0] way;
    } reply_t;

    logic [BLK_W-1:0]   tags   [ENTRIES];
    logic [STAMP_W-1:0] stamps [ENTRIES];
    logic [STAMP_W-1:0] access_count;
    reply_t             replies_due [$];
    int unsigned        fail_total;

    // match against the selected cache, pick the oldest way on a miss, touch on success
    task automatic resolve_request(input logic [SEL_W-1:0] sel, input logic [BLK_W-1:0] blk,
                                   input logic fill, output reply_t r);
        int base;
        int hit_way;
        int way;
        int i;
        r.status = ST_NOZONE;
        r.way    = '0;
        // no-zone wins over the select
        if (blk == '0)
            return;
        if (sel >= CACHES) begin
            r.status = ST_BYPASS;
            return;
        end
        base    = sel * WAYS;
        hit_way = -1;
        for (i = 0; i < WAYS; i++) begin
            if (hit_way < 0 && tags[base + i] == blk)
                hit_way = i;
        end
        if (hit_way >= 0) begin
            way = hit_way;
        end else begin
            way = 0;
            for (i = 1; i < WAYS; i++) begin
                if (stamps[base + i] < stamps[base + way])
                    way = i;
            end
            if (!fill) begin
                r.status = ST_FAILED;
                r.way    = WAYIDX_W'(way);
                return;
            end
        end
        access_count      = access_count + 1'b1;
        stamps[base + way] = access_count;
        tags[base + way]   = blk;
        r.status = (hit_way >= 0) ? ST_HIT : ST_FILLED;
        r.way    = WAYIDX_W'(way);
    endtask

    always @(posedge aclk) begin
        reply_t want;
        reply_t got;
        if (!aresetn) begin
            for (int e = 0; e < ENTRIES; e++) begin
                tags[e]   = '0;
                stamps[e] = '0;
            end
            access_count = '0;
            replies_due.delete();
            fail_total = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                resolve_request(s_tuser[SEL_W-1:0], s_tdata[BLK_W-1:0], s_tdata[BLK_W], want);
                replies_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tuser[STATUS_W-1:0];
                got.way    = m_tdata[WAYIDX_W-1:0];
                if (replies_due.size() == 0) begin
                    $display("%0t: reply word with nothing awaited, status %0d way %0d",
                             $time, got.status, got.way);
                    fail_total++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        fail_total++;
                    end
                    if (got.way != want.way) begin
                        $display("%0t: way_index expected %0d got %0d",
                                 $time, want.way, got.way);
                        fail_total++;
                    end
                end
            end
        end
        mismatches <= fail_total;
        awaiting   <= replies_due.size();
    end

endmodule

/* verif/lru_block_cache_tags_tb.sv */
// testbench top for the lru block cache tag controller: stimulus, watchdog and verdict
module lru_block_cache_tags_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lbct_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // block_number[31:0], fill_ok[32], zero pad
    logic [S_TUSER_W-1:0] s_tuser  = '0;  // cache_select[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // way_index[2:0], zero pad
    logic [M_TUSER_W-1:0] m_tuser;        // status[2:0]

    int unsigned mismatches;
    int unsigned awaiting;
    int unsigned quiet_cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic [BLK_W-1:0] hot_blocks [8];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    lru_block_cache_tags DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lbct_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ends the run when no word moves on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[lru_block_cache_tags] ERROR");
            $finish;
        end
    end

    // valid stays high from one word to the next unless a gap is drawn
    task automatic offer_request(input logic [SEL_W-1:0] sel, input logic [BLK_W-1:0] blk,
                                 input logic fill);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= sel;
        s_tdata  <= S_TDATA_W'({fill, blk});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // mostly a small pool of block numbers so that ways get reused and evicted
    task automatic random_requests(input int idle, input int stall, input int count);
        int k;
        int pick;
        logic [SEL_W-1:0] sel;
        logic [BLK_W-1:0] blk;
        logic fill;
        idle_pct  = idle;
        stall_pct <= stall;
        for (k = 0; k < 8; k++)
            hot_blocks[k] = (k < 4) ? BLK_W'($urandom_range(12, 1)) : BLK_W'($urandom);
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 85)
                sel = SEL_W'($urandom_range(1));
            else
                sel = SEL_W'($urandom_range(3, 2));
            pick = $urandom_range(99);
            if (pick < 4)
                blk = '0;
            else if (pick < 76)
                blk = hot_blocks[$urandom_range(7)];
            else
                blk = $urandom;
            if ($urandom_range(99) < 3)
                hot_blocks[$urandom_range(7)] = $urandom;
            fill = ($urandom_range(99) < 80);
            offer_request(sel, blk, fill);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // no zone, whatever the select and the fill flag
        offer_request(2'd0, 32'd0, 1'b1);
        offer_request(2'd1, 32'd0, 1'b0);
        offer_request(2'd2, 32'd0, 1'b1);
        offer_request(2'd3, 32'd0, 1'b0);
        // bypass selects
        offer_request(2'd2, 32'hFFFF_FFFF, 1'b1);
        offer_request(2'd3, 32'd1, 1'b0);
        // failed fill leaves the empty cache alone, then fill all five ways
        offer_request(2'd0, 32'd1, 1'b0);
        offer_request(2'd0, 32'd1, 1'b1);
        offer_request(2'd0, 32'd2, 1'b1);
        offer_request(2'd0, 32'd3, 1'b1);
        offer_request(2'd0, 32'h8000_0000, 1'b1);
        offer_request(2'd0, 32'hFFFF_FFFF, 1'b1);
        // hits, fill flag ignored
        offer_request(2'd0, 32'd1, 1'b0);
        offer_request(2'd0, 32'hFFFF_FFFF, 1'b1);
        // miss against the oldest way, failed then filled
        offer_request(2'd0, 32'd7, 1'b0);
        offer_request(2'd0, 32'd7, 1'b1);
        // second cache is separate from the first
        offer_request(2'd1, 32'd1, 1'b1);
        offer_request(2'd1, 32'h7FFF_FFFF, 1'b1);
        offer_request(2'd1, 32'd1, 1'b0);
        offer_request(2'd0, 32'd2, 1'b1);
        offer_request(2'd2, 32'h5555_5555, 1'b0);
        offer_request(2'd3, 32'hAAAA_AAAA, 1'b1);

        random_requests(0, 0, 350);
        random_requests(65, 0, 350);
        random_requests(0, 65, 350);
        random_requests(24, 24, 350);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && awaiting == 0)
            $display("[lru_block_cache_tags] OK");
        else
            $display("[lru_block_cache_tags] ERROR");
        $finish;
    end

endmodule

/* sim.f */
hdl/lbct_pkg.sv
hdl/lbct_way_cmp.sv
hdl/lru_block_cache_tags.sv
verif/lbct_checker.sv
verif/lru_block_cache_tags_tb.sv
